>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the supervisor RTL.
// Both macros expect a clock named clk; LHS_ASSERT also expects an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while the block is out of reset.
`define LHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every clock edge, reset included.
`define LHS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/lhs_pkg.sv
package lhs_pkg;

  // Width of every millisecond time stamp and interval.
  localparam int TIME_W = 32;

  // Width of the register index of the configuration port.
  localparam int CFG_IDX_W = 3;

  // Reset values of the configuration registers.
  localparam logic [TIME_W-1:0] CHECK_PERIOD_RST        = TIME_W'(30 * 1000);
  localparam logic [TIME_W-1:0] SERVICE_START_LIMIT_RST = TIME_W'(5 * 60 * 1000);
  localparam logic [TIME_W-1:0] RECONNECT_PERIOD_RST    = TIME_W'(60 * 1000);
  localparam logic [TIME_W-1:0] LINK_DOWN_LIMIT_RST     = TIME_W'(30 * 60 * 1000);
  localparam logic [TIME_W-1:0] RESYNC_PERIOD_RST       = TIME_W'(5 * 60 * 1000);
  localparam logic [TIME_W-1:0] PROBE_PERIOD_RST        = TIME_W'(5 * 60 * 1000);
  localparam logic [TIME_W-1:0] PERIPHERAL_LIMIT_RST    = TIME_W'(30 * 60 * 1000);
  localparam logic [TIME_W-1:0] START_TIME_RST          = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHECK_PERIOD        = 3'd0,
    CFG_SERVICE_START_LIMIT = 3'd1,
    CFG_RECONNECT_PERIOD    = 3'd2,
    CFG_LINK_DOWN_LIMIT     = 3'd3,
    CFG_RESYNC_PERIOD       = 3'd4,
    CFG_PROBE_PERIOD        = 3'd5,
    CFG_PERIPHERAL_LIMIT    = 3'd6,
    CFG_START_TIME          = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_SERVICE  = 3'd1,
    CAUSE_WIRELESS = 3'd2,
    CAUSE_UNSYNCED = 3'd3,
    CAUSE_SILENT   = 3'd4
  } cause_t;

  // One poll after classification by the front end.
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic              svc_up;
    logic              wl_check;
    logic              wl_down;
    logic              pr_check;
    logic              pr_synced;
    logic              rx_seen;
    logic [TIME_W-1:0] last_rx;
  } poll_t;

  // One result beat.
  typedef struct packed {
    logic   check_ran;
    logic   reconnect;
    logic   resync;
    logic   probe;
    logic   reboot;
    cause_t cause;
  } result_t;

  // True when the wrapping distance from since to now has reached limit.
  function automatic logic passed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] since,
                                  logic [TIME_W-1:0] limit);
    logic [TIME_W-1:0] diff;
    diff = now - since;
    return diff >= limit;
  endfunction

endpackage

>>> rtl/core/lhs_front.sv
module lhs_front (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [lhs_pkg::TIME_W-1:0] in_now_ms,
  input  logic                      in_service_up,
  input  logic                      in_mode_known,
  input  logic                      in_station_mode,
  input  logic                      in_has_address,
  input  logic                      in_peer_status_known,
  input  logic                      in_peer_synced,
  input  logic [lhs_pkg::TIME_W-1:0] in_last_receive_ms,
  input  logic                      q_full,
  output logic                      q_push,
  output lhs_pkg::poll_t            q_wdata
);

  // A beat is taken whenever the queue has room.
  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  // Reduce the raw flags to the conditions the checker acts on.
  always_comb begin
    q_wdata.now       = in_now_ms;
    q_wdata.svc_up    = in_service_up;
    q_wdata.wl_check  = in_mode_known;
    q_wdata.wl_down   = in_station_mode & ~in_has_address;
    q_wdata.pr_check  = in_peer_status_known;
    q_wdata.pr_synced = in_peer_synced;
    q_wdata.rx_seen   = (in_last_receive_ms != '0);
    q_wdata.last_rx   = in_last_receive_ms;
  end

endmodule

>>> rtl/core/lhs_queue.sv
`include "assert_macros.svh"

module lhs_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lhs_pkg::poll_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output lhs_pkg::poll_t rdata
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  lhs_pkg::poll_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = slot_r[rd_ptr_r];

  // Pointer and fill-count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage slots carry no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  `LHS_ASSERT(a_q_no_overflow, cnt_r <= CNT_W'(DEPTH), "queue fill count above depth")
  `LHS_ASSERT(a_q_no_underflow, (cnt_r == '0) |-> !pop, "pop from an empty queue")

endmodule

>>> rtl/core/lhs_back.sv
`include "assert_macros.svh"

module lhs_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [lhs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lhs_pkg::TIME_W-1:0]    cfg_wdata,
  input  logic                         q_not_empty,
  input  lhs_pkg::poll_t               q_rdata,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lhs_pkg::result_t             out_res
);

  localparam int TW = lhs_pkg::TIME_W;

  // Configuration registers.
  logic [TW-1:0] check_period_r, svc_limit_r, reconnect_period_r, down_limit_r;
  logic [TW-1:0] resync_period_r, probe_period_r, periph_limit_r, start_time_r;

  // Supervision state.
  logic [TW-1:0] last_check_r, last_check_nxt;
  logic [TW-1:0] down_since_r, down_since_nxt;
  logic [TW-1:0] last_reconn_r, last_reconn_nxt;
  logic [TW-1:0] sync_lost_at_r, sync_lost_at_nxt;
  logic [TW-1:0] last_resync_r, last_resync_nxt;
  logic [TW-1:0] last_probe_r, last_probe_nxt;
  logic          halted_r, halted_nxt;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  lhs_pkg::result_t res_r, res_nxt;

  // Evaluation terms.
  logic          run, svc_fail, wl_act, wl_fail, pr_act, pr_unsync, pr_sync;
  logic          rc_req, rs_req, pb_req, unsync_fail, silent_fail;
  logic [TW-1:0] down_eff, unsync_eff, now;

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // A queued poll moves on whenever the output register is free or being emptied.
  assign q_pop = q_not_empty & (~out_valid_r | ~out_stall);
  assign now   = q_rdata.now;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_period_r     <= lhs_pkg::CHECK_PERIOD_RST;
      svc_limit_r        <= lhs_pkg::SERVICE_START_LIMIT_RST;
      reconnect_period_r <= lhs_pkg::RECONNECT_PERIOD_RST;
      down_limit_r       <= lhs_pkg::LINK_DOWN_LIMIT_RST;
      resync_period_r    <= lhs_pkg::RESYNC_PERIOD_RST;
      probe_period_r     <= lhs_pkg::PROBE_PERIOD_RST;
      periph_limit_r     <= lhs_pkg::PERIPHERAL_LIMIT_RST;
      start_time_r       <= lhs_pkg::START_TIME_RST;
    end else if (cfg_we) begin
      case (lhs_pkg::cfg_idx_t'(cfg_index))
        lhs_pkg::CFG_CHECK_PERIOD:        check_period_r     <= cfg_wdata;
        lhs_pkg::CFG_SERVICE_START_LIMIT: svc_limit_r        <= cfg_wdata;
        lhs_pkg::CFG_RECONNECT_PERIOD:    reconnect_period_r <= cfg_wdata;
        lhs_pkg::CFG_LINK_DOWN_LIMIT:     down_limit_r       <= cfg_wdata;
        lhs_pkg::CFG_RESYNC_PERIOD:       resync_period_r    <= cfg_wdata;
        lhs_pkg::CFG_PROBE_PERIOD:        probe_period_r     <= cfg_wdata;
        lhs_pkg::CFG_PERIPHERAL_LIMIT:    periph_limit_r     <= cfg_wdata;
        lhs_pkg::CFG_START_TIME:          start_time_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Health check: all interval compares run side by side, then the cause is chosen in order.
  always_comb begin
    run = ~halted_r & ((last_check_r == '0) | lhs_pkg::passed(now, last_check_r, check_period_r));

    svc_fail = ~q_rdata.svc_up & lhs_pkg::passed(now, start_time_r, svc_limit_r);

    // Wireless link.
    wl_act   = ~svc_fail & q_rdata.wl_check;
    down_eff = (down_since_r == '0) ? now : down_since_r;
    rc_req   = wl_act & q_rdata.wl_down &
               ((last_reconn_r == '0) | lhs_pkg::passed(now, last_reconn_r, reconnect_period_r));
    wl_fail  = wl_act & q_rdata.wl_down & lhs_pkg::passed(now, down_eff, down_limit_r);

    // Peripheral link.
    pr_act      = ~svc_fail & ~wl_fail & q_rdata.pr_check;
    pr_unsync   = pr_act & ~q_rdata.pr_synced;
    pr_sync     = pr_act & q_rdata.pr_synced;
    unsync_eff  = (sync_lost_at_r == '0) ? now : sync_lost_at_r;
    rs_req      = pr_unsync &
                  ((last_resync_r == '0) | lhs_pkg::passed(now, last_resync_r, resync_period_r));
    unsync_fail = pr_unsync & lhs_pkg::passed(now, unsync_eff, periph_limit_r);
    pb_req      = pr_sync & q_rdata.rx_seen &
                  ((last_probe_r == '0) | lhs_pkg::passed(now, last_probe_r, probe_period_r)) &
                  lhs_pkg::passed(now, q_rdata.last_rx, probe_period_r);
    silent_fail = pr_sync & q_rdata.rx_seen &
                  lhs_pkg::passed(now, q_rdata.last_rx, periph_limit_r);
  end

  // Result of the poll at the head of the queue.
  always_comb begin
    res_nxt.check_ran = run;
    res_nxt.reconnect = run & rc_req;
    res_nxt.resync    = run & rs_req;
    res_nxt.probe     = run & pb_req;
    res_nxt.cause     = lhs_pkg::CAUSE_NONE;
    if (run) begin
      if (svc_fail) begin
        res_nxt.cause = lhs_pkg::CAUSE_SERVICE;
      end else if (wl_fail) begin
        res_nxt.cause = lhs_pkg::CAUSE_WIRELESS;
      end else if (unsync_fail) begin
        res_nxt.cause = lhs_pkg::CAUSE_UNSYNCED;
      end else if (silent_fail) begin
        res_nxt.cause = lhs_pkg::CAUSE_SILENT;
      end
    end
    res_nxt.reboot = (res_nxt.cause != lhs_pkg::CAUSE_NONE);
  end

  // State update, taken only when a check runs on a popped poll.
  always_comb begin
    last_check_nxt   = last_check_r;
    down_since_nxt   = down_since_r;
    last_reconn_nxt  = last_reconn_r;
    sync_lost_at_nxt = sync_lost_at_r;
    last_resync_nxt  = last_resync_r;
    last_probe_nxt   = last_probe_r;
    halted_nxt       = halted_r;
    if (q_pop && run) begin
      last_check_nxt = now;
      if (wl_act) begin
        down_since_nxt = q_rdata.wl_down ? down_eff : '0;
      end
      if (rc_req) begin
        last_reconn_nxt = now;
      end
      if (pr_unsync) begin
        sync_lost_at_nxt = unsync_eff;
        if (rs_req) begin
          last_resync_nxt = now;
        end
      end else if (pr_sync) begin
        sync_lost_at_nxt = '0;
        last_resync_nxt  = '0;
      end
      if (pb_req) begin
        last_probe_nxt = now;
      end
      halted_nxt = res_nxt.reboot;
    end
  end

  // Output register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_check_r   <= '0;
      down_since_r   <= '0;
      last_reconn_r  <= '0;
      sync_lost_at_r <= '0;
      last_resync_r  <= '0;
      last_probe_r   <= '0;
      halted_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      last_check_r   <= last_check_nxt;
      down_since_r   <= down_since_nxt;
      last_reconn_r  <= last_reconn_nxt;
      sync_lost_at_r <= sync_lost_at_nxt;
      last_resync_r  <= last_resync_nxt;
      last_probe_r   <= last_probe_nxt;
      halted_r       <= halted_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Result payload carries no reset.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  `LHS_ASSERT(a_reboot_halts, (q_pop && res_nxt.reboot) |=> halted_r,
              "reboot result did not latch halted")
  `LHS_ASSERT(a_halt_sticks, halted_r |=> halted_r, "halted cleared without reset")
  `LHS_ASSERT(a_halted_quiet, (q_pop && halted_r) |=> (!res_r.check_ran && !res_r.reboot),
              "check ran while halted")

endmodule

>>> rtl/core/link_health_supervisor_core.sv
// Link health supervisor.
// Each input beat is one supervisor poll (time stamp plus service, wireless and
// peripheral status); each poll yields exactly one result beat carrying the
// check flag, the reconnect, resync and probe requests and any reboot cause.
// The user is to write the configuration registers through cfg_we, cfg_index and
// cfg_wdata only while no poll is in flight (not enforced by the block); writes
// take effect at the next clock edge. An accepted poll waits in the queue and
// is then checked into the output register. Throughput: one poll per cycle
// while out_stall is low, set by the back-end check, where all interval
// compares run in parallel against the stored time stamps. A two-entry queue
// sits between the input side and the check; when the result channel stalls,
// the output register holds its beat and the queue fills until in_stall rises.
// Reset clears all stored time stamps and the halted flag, empties the queue and
// loads the default intervals. After a reboot result the block stays halted and
// answers every further poll with an all-zero result until the next reset.
module link_health_supervisor_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lhs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lhs_pkg::TIME_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lhs_pkg::TIME_W-1:0]    in_now_ms,
  input  logic                          in_service_up,
  input  logic                          in_mode_known,
  input  logic                          in_station_mode,
  input  logic                          in_has_address,
  input  logic                          in_peer_status_known,
  input  logic                          in_peer_synced,
  input  logic [lhs_pkg::TIME_W-1:0]    in_last_receive_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_check_ran,
  output logic                          out_reconnect_request,
  output logic                          out_resync_request,
  output logic                          out_probe_request,
  output logic                          out_reboot_request,
  output logic [2:0]                    out_reboot_cause
);

  logic             q_full, q_push, q_pop, q_not_empty;
  lhs_pkg::poll_t   q_wdata, q_rdata;
  lhs_pkg::result_t res;

  // Input side: classify and enqueue.
  lhs_front u_front (
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_now_ms            (in_now_ms),
    .in_service_up        (in_service_up),
    .in_mode_known        (in_mode_known),
    .in_station_mode      (in_station_mode),
    .in_has_address       (in_has_address),
    .in_peer_status_known (in_peer_status_known),
    .in_peer_synced       (in_peer_synced),
    .in_last_receive_ms   (in_last_receive_ms),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_wdata              (q_wdata)
  );

  lhs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  // Check side: state, configuration and output register.
  lhs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (res)
  );

  assign out_check_ran         = res.check_ran;
  assign out_reconnect_request = res.reconnect;
  assign out_resync_request    = res.resync;
  assign out_probe_request     = res.probe;
  assign out_reboot_request    = res.reboot;
  assign out_reboot_cause      = res.cause;

endmodule

>>> test/link_health_supervisor_core_tb.sv
`timescale 1ns / 100ps

module link_health_supervisor_core_tb;
  import lhs_pkg::*;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // One poll as driven onto the input channel.
  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              service_up;
    logic              mode_known;
    logic              station_mode;
    logic              has_address;
    logic              peer_known;
    logic              peer_synced;
    logic [TIME_W-1:0] last_rx;
  } poll_beat_t;

  // One verdict as seen on the result channel.
  typedef struct packed {
    logic   check_ran;
    logic   reconnect;
    logic   resync;
    logic   probe;
    logic   reboot;
    cause_t cause;
  } verdict_t;

  // Time stamps kept by the supervisor between polls; zero means never.
  typedef struct packed {
    logic [TIME_W-1:0] last_check;
    logic [TIME_W-1:0] down_since;
    logic [TIME_W-1:0] last_reconnect;
    logic [TIME_W-1:0] sync_lost_at;
    logic [TIME_W-1:0] last_resync;
    logic [TIME_W-1:0] last_probe;
    logic              halted;
  } health_t;

  // A row of the opening script; typed rows carry the verdict to expect.
  typedef struct packed {
    poll_beat_t beat;
    logic       typed;
    verdict_t   want;
  } script_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  cfg_idx_t          cfg_index = CFG_CHECK_PERIOD;
  logic [TIME_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic              in_service_up = 1'b0;
  logic              in_mode_known = 1'b0;
  logic              in_station_mode = 1'b0;
  logic              in_has_address = 1'b0;
  logic              in_peer_status_known = 1'b0;
  logic              in_peer_synced = 1'b0;
  logic [TIME_W-1:0] in_last_receive_ms = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_check_ran;
  logic              out_reconnect_request;
  logic              out_resync_request;
  logic              out_probe_request;
  logic              out_reboot_request;
  logic [2:0]        out_reboot_cause;

  // Shadow of the block: registers, stored time stamps and pending verdicts.
  logic [TIME_W-1:0] cfg_shadow [8];
  logic [TIME_W-1:0] next_settings [8];
  health_t           health;
  verdict_t          verdicts_due [$];
  script_row_t       poll_script [$];
  logic [TIME_W-1:0] last_now = '0;
  logic [5:0]        live_flags = 6'b111111;
  int unsigned       send_gap_pct = 34;
  int unsigned       stall_pct = 72;
  int unsigned       mismatches = 0;

  link_health_supervisor_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_now_ms            (in_now_ms),
    .in_service_up        (in_service_up),
    .in_mode_known        (in_mode_known),
    .in_station_mode      (in_station_mode),
    .in_has_address       (in_has_address),
    .in_peer_status_known (in_peer_status_known),
    .in_peer_synced       (in_peer_synced),
    .in_last_receive_ms   (in_last_receive_ms),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_check_ran        (out_check_ran),
    .out_reconnect_request(out_reconnect_request),
    .out_resync_request   (out_resync_request),
    .out_probe_request    (out_probe_request),
    .out_reboot_request   (out_reboot_request),
    .out_reboot_cause     (out_reboot_cause)
  );

  always #5 clk = ~clk;

  // True once the wrapping distance from since to stamp has reached span.
  function automatic logic elapsed_reached(logic [TIME_W-1:0] stamp, logic [TIME_W-1:0] since,
                                           logic [TIME_W-1:0] span);
    logic [TIME_W-1:0] span_gone;
    span_gone = stamp - since;
    return span_gone >= span;
  endfunction

  // Works out the verdict of one poll and advances the shadow time stamps.
  function automatic verdict_t assess_poll(poll_beat_t p);
    verdict_t          v;
    logic [TIME_W-1:0] stamp;
    v = '0;
    stamp = p.now_ms;
    if (!health.halted && (health.last_check == '0 ||
        elapsed_reached(stamp, health.last_check, cfg_shadow[CFG_CHECK_PERIOD]))) begin
      v.check_ran = 1'b1;
      health.last_check = stamp;

      if (!p.service_up && elapsed_reached(stamp, cfg_shadow[CFG_START_TIME],
                                           cfg_shadow[CFG_SERVICE_START_LIMIT])) begin
        v.cause = CAUSE_SERVICE;
      end

      // Wireless: only a station without an address counts as down.
      if (v.cause == CAUSE_NONE && p.mode_known) begin
        if (!p.station_mode || p.has_address) begin
          health.down_since = '0;
        end else begin
          if (health.down_since == '0) health.down_since = stamp;
          if (health.last_reconnect == '0 ||
              elapsed_reached(stamp, health.last_reconnect, cfg_shadow[CFG_RECONNECT_PERIOD])) begin
            v.reconnect = 1'b1;
            health.last_reconnect = stamp;
          end
          if (elapsed_reached(stamp, health.down_since, cfg_shadow[CFG_LINK_DOWN_LIMIT])) begin
            v.cause = CAUSE_WIRELESS;
          end
        end
      end

      // Peripheral: resync while unsynced, probe and silence watch once synced.
      if (v.cause == CAUSE_NONE && p.peer_known) begin
        if (!p.peer_synced) begin
          if (health.sync_lost_at == '0) health.sync_lost_at = stamp;
          if (health.last_resync == '0 ||
              elapsed_reached(stamp, health.last_resync, cfg_shadow[CFG_RESYNC_PERIOD])) begin
            v.resync = 1'b1;
            health.last_resync = stamp;
          end
          if (elapsed_reached(stamp, health.sync_lost_at, cfg_shadow[CFG_PERIPHERAL_LIMIT])) begin
            v.cause = CAUSE_UNSYNCED;
          end
        end else begin
          health.sync_lost_at = '0;
          health.last_resync = '0;
          if (p.last_rx != '0) begin
            if ((health.last_probe == '0 ||
                 elapsed_reached(stamp, health.last_probe, cfg_shadow[CFG_PROBE_PERIOD])) &&
                elapsed_reached(stamp, p.last_rx, cfg_shadow[CFG_PROBE_PERIOD])) begin
              v.probe = 1'b1;
              health.last_probe = stamp;
            end
            if (elapsed_reached(stamp, p.last_rx, cfg_shadow[CFG_PERIPHERAL_LIMIT])) begin
              v.cause = CAUSE_SILENT;
            end
          end
        end
      end

      if (v.cause != CAUSE_NONE) begin
        v.reboot = 1'b1;
        health.halted = 1'b1;
      end
    end
    return v;
  endfunction

  // Looks ahead without disturbing the shadow state.
  function automatic logic would_reboot(poll_beat_t p);
    health_t  saved;
    verdict_t v;
    saved = health;
    v = assess_poll(p);
    health = saved;
    return v.reboot;
  endfunction

  // Random poll around the current time, steered away from a reboot so that
  // the supervisor stays live until the closing phase.
  function automatic poll_beat_t next_random_poll(int unsigned scale);
    poll_beat_t  p;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) p.now_ms = '0;
    else if (pick < 8) p.now_ms = last_now;
    else if (pick < 18)
      p.now_ms = health.last_check + cfg_shadow[CFG_CHECK_PERIOD] - $urandom_range(1);
    else if (pick < 25) p.now_ms = $urandom();
    else p.now_ms = last_now + $urandom_range(2 * scale);

    // Status flags persist for a while so that outages build up.
    for (int b = 0; b < 6; b++) begin
      if ($urandom_range(99) < 15) live_flags[b] = ~live_flags[b];
    end
    {p.service_up, p.mode_known, p.station_mode, p.has_address,
     p.peer_known, p.peer_synced} = live_flags;

    pick = $urandom_range(99);
    if (pick < 25) p.last_rx = '0;
    else if (pick < 40) p.last_rx = p.now_ms - cfg_shadow[CFG_PROBE_PERIOD] + $urandom_range(1);
    else if (pick < 50) p.last_rx = $urandom();
    else if (pick < 55) p.last_rx = TIME_MAX;
    else p.last_rx = p.now_ms - $urandom_range(2 * scale);

    if (would_reboot(p)) p.service_up = 1'b1;
    if (would_reboot(p)) p.has_address = 1'b1;
    if (would_reboot(p)) begin
      p.peer_synced = 1'b1;
      p.last_rx = '0;
    end
    return p;
  endfunction

  function automatic script_row_t mk_row(logic [TIME_W-1:0] stamp, logic [5:0] flags,
                                        logic [TIME_W-1:0] rx, logic typed,
                                        logic [4:0] want_flags);
    script_row_t r;
    r = '0;
    r.beat.now_ms = stamp;
    {r.beat.service_up, r.beat.mode_known, r.beat.station_mode, r.beat.has_address,
     r.beat.peer_known, r.beat.peer_synced} = flags;
    r.beat.last_rx = rx;
    r.typed = typed;
    {r.want.check_ran, r.want.reconnect, r.want.resync, r.want.probe, r.want.reboot} = want_flags;
    r.want.cause = CAUSE_NONE;
    return r;
  endfunction

  function automatic void stage_settings(logic [TIME_W-1:0] check, svc, reconn, down,
                                         resync, probe, silent, start);
    next_settings[CFG_CHECK_PERIOD]        = check;
    next_settings[CFG_SERVICE_START_LIMIT] = svc;
    next_settings[CFG_RECONNECT_PERIOD]    = reconn;
    next_settings[CFG_LINK_DOWN_LIMIT]     = down;
    next_settings[CFG_RESYNC_PERIOD]       = resync;
    next_settings[CFG_PROBE_PERIOD]        = probe;
    next_settings[CFG_PERIPHERAL_LIMIT]    = silent;
    next_settings[CFG_START_TIME]          = start;
  endfunction

  // Register settings per phase, with the time step that suits them.
  task automatic choose_settings(int phase, output int unsigned scale);
    case (phase)
      0: begin
        stage_settings($urandom_range(1, 8), $urandom_range(20, 200), $urandom_range(1, 20),
                       $urandom_range(20, 200), $urandom_range(1, 20), $urandom_range(1, 20),
                       $urandom_range(20, 200), $urandom_range(100));
        scale = 8;
      end
      1: begin
        stage_settings('0, $urandom_range(10, 100), '0, $urandom_range(10, 100), '0, '0,
                       $urandom_range(10, 100), $urandom());
        scale = 8;
      end
      2: begin
        stage_settings(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX,
                       TIME_MAX);
        scale = 1 << 20;
      end
      3: begin
        stage_settings($urandom_range(1, 500), $urandom_range(1000, 20000),
                       $urandom_range(1, 1000), $urandom_range(1000, 20000),
                       $urandom_range(1, 1000), $urandom_range(1, 1000),
                       $urandom_range(1000, 20000), $urandom());
        scale = 500;
      end
      4: begin
        stage_settings(1, $urandom_range(1, 40), 1, 1, 1, 1, $urandom_range(1, 40), '0);
        scale = 4;
      end
      default: begin
        stage_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom());
        scale = $urandom_range(1, 1 << 20);
      end
    endcase
  endtask

  // Writes the staged settings once every verdict has come back.
  task automatic program_settings();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= next_settings[i];
      cfg_shadow[i] = next_settings[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Offers one poll beat, holding it until accepted, then records its verdict.
  task automatic send_poll(poll_beat_t p, logic typed, verdict_t typed_want);
    verdict_t want;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_now_ms            <= p.now_ms;
    in_service_up        <= p.service_up;
    in_mode_known        <= p.mode_known;
    in_station_mode      <= p.station_mode;
    in_has_address       <= p.has_address;
    in_peer_status_known <= p.peer_known;
    in_peer_synced       <= p.peer_synced;
    in_last_receive_ms   <= p.last_rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = assess_poll(p);
    verdicts_due.push_back(typed ? typed_want : want);
    last_now = p.now_ms;
  endtask

  // Result side: random stall and comparison of every accepted beat.
  always @(posedge clk) begin : result_monitor
    verdict_t got;
    verdict_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.check_ran = out_check_ran;
        got.reconnect = out_reconnect_request;
        got.resync    = out_resync_request;
        got.probe     = out_probe_request;
        got.reboot    = out_reboot_request;
        got.cause     = cause_t'(out_reboot_cause);
        if (verdicts_due.size() == 0) begin
          if (mismatches < 10) $display("%0t: result beat with no poll outstanding", $realtime);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("%0t: verdict mismatch, expected ran %b reconnect %b resync %b probe %b",
                       $realtime, want.check_ran, want.reconnect, want.resync, want.probe,
                       " reboot %b cause %0d", want.reboot, want.cause);
              $display("    got ran %b reconnect %b resync %b probe %b reboot %b cause %0d",
                       got.check_ran, got.reconnect, got.resync, got.probe, got.reboot,
                       got.cause);
            end
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : stimulus
    poll_beat_t  p;
    verdict_t    no_verdict;
    int unsigned scale;
    int unsigned cause_pick;

    no_verdict = '0;
    health = '0;
    cfg_shadow[CFG_CHECK_PERIOD]        = CHECK_PERIOD_RST;
    cfg_shadow[CFG_SERVICE_START_LIMIT] = SERVICE_START_LIMIT_RST;
    cfg_shadow[CFG_RECONNECT_PERIOD]    = RECONNECT_PERIOD_RST;
    cfg_shadow[CFG_LINK_DOWN_LIMIT]     = LINK_DOWN_LIMIT_RST;
    cfg_shadow[CFG_RESYNC_PERIOD]       = RESYNC_PERIOD_RST;
    cfg_shadow[CFG_PROBE_PERIOD]        = PROBE_PERIOD_RST;
    cfg_shadow[CFG_PERIPHERAL_LIMIT]    = PERIPHERAL_LIMIT_RST;
    cfg_shadow[CFG_START_TIME]          = START_TIME_RST;

    // Opening script under the reset intervals. Flags are service, mode known,
    // station, address, peer known, peer synced; verdicts are ran, reconnect,
    // resync, probe, reboot.
    poll_script.push_back(mk_row(0,      6'b000000, 0, 1, 5'b10000));
    // Polls at time zero keep the check and outage stamps at never.
    poll_script.push_back(mk_row(0,      6'b111010, 0, 1, 5'b11100));
    poll_script.push_back(mk_row(1000,   6'b111010, 0, 1, 5'b11100));
    poll_script.push_back(mk_row(2000,   6'b111010, 0, 1, 5'b00000));
    poll_script.push_back(mk_row(31000,  6'b111010, 0, 1, 5'b10000));
    // The link recovers; the reconnect stamp is kept, so only the next outage
    // after the spacing asks again.
    poll_script.push_back(mk_row(61000,  6'b111110, 0, 1, 5'b10000));
    poll_script.push_back(mk_row(91000,  6'b111010, 0, 1, 5'b11000));
    // Synced with no receive yet: no probe.
    poll_script.push_back(mk_row(121000, 6'b111111, 0, 1, 5'b10000));
    poll_script.push_back(mk_row(151000, 6'b111111, 1, 0, 5'b00000));
    poll_script.push_back(mk_row(401000, 6'b111111, 1, 1, 5'b10010));
    poll_script.push_back(mk_row(431000, 6'b111111, 1, 0, 5'b00000));
    // Top of the time range, then a check across the wrap.
    poll_script.push_back(mk_row(TIME_MAX, 6'b101011, TIME_MAX, 0, 5'b00000));
    poll_script.push_back(mk_row(29999,  6'b110011, TIME_MAX, 0, 5'b00000));
    // Sync loss after a synced check asks for a resync at once.
    poll_script.push_back(mk_row(59999,  6'b010010, TIME_MAX, 1, 5'b10100));
    poll_script.push_back(mk_row(59999,  6'b010010, TIME_MAX, 1, 5'b00000));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (poll_script[i]) begin
      send_poll(poll_script[i].beat, poll_script[i].typed, poll_script[i].want);
    end

    // Random phases: receiver-heavy stalling, then sender-heavy idling, then none.
    for (int phase = 0; phase < 6; phase++) begin
      choose_settings(phase, scale);
      program_settings();
      send_gap_pct = (phase < 2) ? 34 : (phase < 4) ? 72 : 0;
      stall_pct    = (phase < 2) ? 72 : (phase < 4) ? 34 : 0;
      repeat (235) send_poll(next_random_poll(scale), 1'b0, no_verdict);
    end

    // Closing phase: a zero limit forces one chosen reboot cause, after which
    // the supervisor must stay halted through further polls and a rewrite.
    cause_pick = $urandom_range(1, 4);
    stage_settings('0, (cause_pick == 1) ? '0 : TIME_MAX, $urandom_range(1, 100),
                   (cause_pick == 2) ? '0 : TIME_MAX, $urandom_range(1, 100),
                   $urandom_range(1, 100), (cause_pick >= 3) ? '0 : TIME_MAX, '0);
    program_settings();
    p = '0;
    p.now_ms       = last_now + 1;
    p.service_up   = (cause_pick != 1);
    p.mode_known   = (cause_pick == 2);
    p.station_mode = 1'b1;
    p.peer_known   = (cause_pick >= 3);
    p.peer_synced  = (cause_pick == 4);
    p.last_rx      = (cause_pick == 4) ? ($urandom() | 1) : '0;
    send_poll(p, 1'b0, no_verdict);
    repeat (12) send_poll(next_random_poll(16), 1'b0, no_verdict);
    choose_settings(5, scale);
    program_settings();
    repeat (12) send_poll(next_random_poll(scale), 1'b0, no_verdict);

    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/lhs_pkg.sv
rtl/core/lhs_front.sv
rtl/core/lhs_queue.sv
rtl/core/lhs_back.sv
rtl/core/link_health_supervisor_core.sv
test/link_health_supervisor_core_tb.sv
